FILE: design/lgs_pkg.sv
// shared types and constants for the life grid generation step block
`timescale 1ns / 1ps

package lgs_pkg;

  // fixed field widths of the item ports
  localparam int ROW_IDX_W = 4;
  localparam int CELLS_W   = 12;

  // operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // life rule neighbor counts
  localparam logic [3:0] LIFE_BIRTH   = 4'd3;
  localparam logic [3:0] LIFE_SURVIVE = 4'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } lgs_state_t;

  // controls from the sequencer to the row cells and the output register
  typedef struct packed {
    logic write;
    logic step;
    logic shift;
    logic last;
  } lgs_ctrl_t;

endpackage

FILE: design/lgs_row_cell.sv
// one grid row: holds its cells, applies the life rule, rotates along the chain
`timescale 1ns / 1ps

module lgs_row_cell #(
  parameter int GRID_WIDTH = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lgs_pkg::lgs_ctrl_t    ctrl,
  input  logic                  wr_sel,
  input  logic [GRID_WIDTH-1:0] wr_cells,
  input  logic [GRID_WIDTH-1:0] up,
  input  logic [GRID_WIDTH-1:0] down,
  input  logic [GRID_WIDTH-1:0] shift_in,
  output logic [GRID_WIDTH-1:0] row
);

  logic [GRID_WIDTH+1:0] up_pad;
  logic [GRID_WIDTH+1:0] mid_pad;
  logic [GRID_WIDTH+1:0] dn_pad;
  logic [GRID_WIDTH-1:0] life;
  logic [GRID_WIDTH-1:0] row_next;

  // dead border on both sides, column x sits at pad position x+1
  assign up_pad  = {1'b0, up, 1'b0};
  assign mid_pad = {1'b0, row, 1'b0};
  assign dn_pad  = {1'b0, down, 1'b0};

  for (genvar x = 0; x < GRID_WIDTH; x++) begin : g_col
    logic [3:0] nbr;
    assign nbr = 4'(up_pad[x]) + 4'(up_pad[x+1]) + 4'(up_pad[x+2])
               + 4'(mid_pad[x]) + 4'(mid_pad[x+2])
               + 4'(dn_pad[x]) + 4'(dn_pad[x+1]) + 4'(dn_pad[x+2]);
    assign life[x] = (nbr == lgs_pkg::LIFE_BIRTH)
                  || (row[x] && (nbr == lgs_pkg::LIFE_SURVIVE));
  end

  always_comb begin
    row_next = row;
    if (ctrl.step) begin
      row_next = life;
    end else if (ctrl.write && wr_sel) begin
      row_next = wr_cells;
    end else if (ctrl.shift) begin
      row_next = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else begin
      row <= row_next;
    end
  end

endmodule

FILE: design/lgs_seq.sv
// sequencer: item acceptance, emit state and row counter
`timescale 1ns / 1ps

module lgs_seq #(
  parameter int GRID_HEIGHT = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               op,
  input  logic                               out_valid,
  input  logic                               out_stall,
  output logic                               in_stall,
  output lgs_pkg::lgs_ctrl_t                 ctrl,
  output logic [$clog2(GRID_HEIGHT)-1:0]     row_cnt
);

  localparam int RW = $clog2(GRID_HEIGHT);

  lgs_pkg::lgs_state_t state;
  lgs_pkg::lgs_state_t state_next;
  logic [RW-1:0]       row_cnt_next;
  logic                accept;
  logic                out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // outputs
  always_comb begin
    in_stall   = (state != lgs_pkg::ST_IDLE);
    ctrl.write = accept && (op == lgs_pkg::OP_WRITE);
    ctrl.step  = accept && (op == lgs_pkg::OP_STEP);
    ctrl.shift = (state == lgs_pkg::ST_EMIT) && out_free;
    ctrl.last  = (row_cnt == RW'(GRID_HEIGHT - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lgs_pkg::ST_IDLE: begin
        if (ctrl.step) begin
          state_next = lgs_pkg::ST_EMIT;
        end
      end
      lgs_pkg::ST_EMIT: begin
        if (ctrl.shift && ctrl.last) begin
          state_next = lgs_pkg::ST_IDLE;
        end
      end
      default: state_next = lgs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    row_cnt_next = row_cnt;
    if (ctrl.shift) begin
      row_cnt_next = ctrl.last ? '0 : row_cnt + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lgs_pkg::ST_IDLE;
      row_cnt <= '0;
    end else begin
      state   <= state_next;
      row_cnt <= row_cnt_next;
    end
  end

endmodule

FILE: design/life_grid_generation_step.sv
// life grid generation step: top level with row cell chain and output register
// a write item updates its row at the accept edge; a step item updates the whole grid at the
//   accept edge, then the emit state loads the first row into the output register
// a step item holds the input stalled for the whole emit pass, while one row per cycle leaves
//   through the output register whenever the output is not stalled
// reset: synchronous, clears every cell to dead and returns to idle
`timescale 1ns / 1ps

module life_grid_generation_step #(
  parameter int GRID_WIDTH  = 12,
  parameter int GRID_HEIGHT = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [lgs_pkg::ROW_IDX_W-1:0] row_index,
  input  logic [lgs_pkg::CELLS_W-1:0]   row_cells,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lgs_pkg::ROW_IDX_W-1:0] out_row,
  output logic [lgs_pkg::CELLS_W-1:0]   out_cells,
  output logic                          last_row
);

  localparam int RW = $clog2(GRID_HEIGHT);
  // common width for widening the fixed-width ports against the grid size
  localparam int CW = (GRID_WIDTH > lgs_pkg::CELLS_W) ? GRID_WIDTH : lgs_pkg::CELLS_W;
  localparam int IW = (RW > lgs_pkg::ROW_IDX_W) ? RW : lgs_pkg::ROW_IDX_W;
  localparam int SW = (IW > 7) ? IW : 7;

  lgs_pkg::lgs_ctrl_t    ctrl;
  logic [RW-1:0]         row_cnt;
  logic [GRID_WIDTH-1:0] rows [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] wr_cells;
  logic [CW-1:0]         wr_ext;
  logic [CW-1:0]         head_ext;
  logic [IW-1:0]         idx_ext;
  logic [IW-1:0]         cnt_ext;

  // incoming row: drop columns past the grid width
  assign wr_ext   = CW'(row_cells);
  assign wr_cells = wr_ext[GRID_WIDTH-1:0];
  assign idx_ext  = IW'(row_index);

  // the head of the chain is the row being emitted
  assign head_ext = CW'(rows[0]);
  assign cnt_ext  = IW'(row_cnt);

  lgs_seq #(
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctrl      (ctrl),
    .row_cnt   (row_cnt)
  );

  // chain of row cells: each sees its vertical neighbors for the life rule,
  // and on a shift takes the row below it, the head wrapping to the tail, so
  // after GRID_HEIGHT shifts every row is back in its own cell
  for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_row
    localparam int NXT = (i + 1) % GRID_HEIGHT;
    logic [GRID_WIDTH-1:0] up_row;
    logic [GRID_WIDTH-1:0] dn_row;
    logic                  sel;

    if (i > 0) begin : g_up
      assign up_row = rows[i-1];
    end else begin : g_up_edge
      assign up_row = '0;
    end

    if (i < GRID_HEIGHT - 1) begin : g_dn
      assign dn_row = rows[i+1];
    end else begin : g_dn_edge
      assign dn_row = '0;
    end

    // a row index past the grid matches no cell, so the write is dropped
    assign sel = (SW'(idx_ext) == SW'(i));

    lgs_row_cell #(
      .GRID_WIDTH (GRID_WIDTH)
    ) u_row (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wr_sel   (sel),
      .wr_cells (wr_cells),
      .up       (up_row),
      .down     (dn_row),
      .shift_in (rows[NXT]),
      .row      (rows[i])
    );
  end

  // output register, loaded with the head row on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.shift) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      out_row   <= cnt_ext[lgs_pkg::ROW_IDX_W-1:0];
      out_cells <= head_ext[lgs_pkg::CELLS_W-1:0];
      last_row  <= ctrl.last;
    end
  end

  // a step item always starts an emit pass
  a_step_starts_emit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (op == lgs_pkg::OP_STEP)) |=> in_stall)
    else $error("step item did not start row emission");

  // the emit pass ends only after the last row has been loaded
  a_emit_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(in_stall)) |-> $past(ctrl.shift && ctrl.last))
    else $error("emission ended before the last row");

  // the last-row mark agrees with the emitted row index
  a_last_matches_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(rst)) |->
      (last_row == (out_row == lgs_pkg::ROW_IDX_W'(GRID_HEIGHT - 1))))
    else $error("last row mark does not match row index");

endmodule

FILE: tb/life_grid_checker.sv
// watches both item channels of the life grid block, predicts each generation and compares rows
`timescale 1ns / 1ps

module life_grid_checker #(
  parameter int GRID_W = 12,
  parameter int GRID_H = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          op,
  input  logic [lgs_pkg::ROW_IDX_W-1:0] row_index,
  input  logic [lgs_pkg::CELLS_W-1:0]   row_cells,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lgs_pkg::ROW_IDX_W-1:0] out_row,
  input  logic [lgs_pkg::CELLS_W-1:0]   out_cells,
  input  logic                          last_row,
  output int                            fail_count,
  output int                            rows_pending
);

  localparam int ROW_IDX_W = lgs_pkg::ROW_IDX_W;
  localparam int CELLS_W   = lgs_pkg::CELLS_W;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [CELLS_W-1:0]   cells;
    logic                 last;
  } grid_row_t;

  logic [CELLS_W-1:0] life_grid [GRID_H];
  grid_row_t          expected_rows [$];

  initial begin
    fail_count   = 0;
    rows_pending = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic int live_at(logic [CELLS_W-1:0] r, int x);
    if (x < 0 || x >= GRID_W)
      return 0;
    return int'(r[x]);
  endfunction

  // one generation of B3/S23, cells beyond the edges are dead
  task automatic advance_life_grid();
    logic [CELLS_W-1:0] fresh [GRID_H];
    logic [CELLS_W-1:0] up, mid, down;
    int n;
    for (int y = 0; y < GRID_H; y++) begin
      up   = (y > 0) ? life_grid[y-1] : '0;
      mid  = life_grid[y];
      down = (y + 1 < GRID_H) ? life_grid[y+1] : '0;
      fresh[y] = '0;
      for (int x = 0; x < GRID_W; x++) begin
        n = live_at(up, x-1) + live_at(up, x) + live_at(up, x+1)
          + live_at(mid, x-1) + live_at(mid, x+1)
          + live_at(down, x-1) + live_at(down, x) + live_at(down, x+1);
        if (mid[x])
          fresh[y][x] = (n == lgs_pkg::LIFE_SURVIVE) || (n == lgs_pkg::LIFE_BIRTH);
        else
          fresh[y][x] = (n == lgs_pkg::LIFE_BIRTH);
      end
    end
    for (int y = 0; y < GRID_H; y++)
      life_grid[y] = fresh[y];
  endtask

  always @(posedge clk) begin
    grid_row_t want;
    if (rst) begin
      for (int y = 0; y < GRID_H; y++)
        life_grid[y] = '0;
      expected_rows.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("unexpected row item", int'(out_row), 0);
        end else begin
          want = expected_rows.pop_front();
          if (out_row !== want.row)
            report_mismatch("out_row", int'(out_row), int'(want.row));
          if (out_cells !== want.cells)
            report_mismatch("out_cells", int'(out_cells), int'(want.cells));
          if (last_row !== want.last)
            report_mismatch("last_row", int'(last_row), int'(want.last));
        end
      end
      if (in_valid && !in_stall) begin
        if (op == lgs_pkg::OP_STEP) begin
          advance_life_grid();
          for (int y = 0; y < GRID_H; y++) begin
            want.row   = ROW_IDX_W'(y);
            want.cells = life_grid[y];
            want.last  = (y == GRID_H - 1);
            expected_rows.push_back(want);
          end
        end else if (row_index < GRID_H) begin
          life_grid[row_index] = row_cells;
        end
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

FILE: tb/life_grid_generation_step_tb.sv
// stimulus and verdict for the life grid generation step block
`timescale 1ns / 1ps

module life_grid_generation_step_tb;

  localparam int ROW_IDX_W    = lgs_pkg::ROW_IDX_W;
  localparam int CELLS_W      = lgs_pkg::CELLS_W;
  localparam int GRID_W       = 12;
  localparam int GRID_H       = 10;
  localparam int RANDOM_ITEMS = 330;
  // worst case is every row of every item stalled; the limit allows for that several times over
  localparam int CYCLE_LIMIT  = 400000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [ROW_IDX_W-1:0] row_index;
  logic [CELLS_W-1:0]   row_cells;
  logic                 out_valid;
  logic                 out_stall;
  logic [ROW_IDX_W-1:0] out_row;
  logic [CELLS_W-1:0]   out_cells;
  logic                 last_row;

  int fail_count;
  int rows_pending;
  int cycle_count = 0;
  int items_sent  = 0;
  // receiver hold-off request, counted down by the receiver itself
  int hold_request = 0;
  // when set, neither side inserts gaps
  bit calm = 0;

  life_grid_generation_step #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .row_index(row_index),
    .row_cells(row_cells),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row  (out_row),
    .out_cells(out_cells),
    .last_row (last_row)
  );

  life_grid_checker #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .row_index   (row_index),
    .row_cells   (row_cells),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_row     (out_row),
    .out_cells   (out_cells),
    .last_row    (last_row),
    .fail_count  (fail_count),
    .rows_pending(rows_pending)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run guard: a hung handshake ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // wait drawn per item at random, none during calm stretches
  function automatic int pick_gap();
    if (calm)
      return 0;
    return $urandom_range(0, 8);
  endfunction

  // cell rows of varied density so births, deaths and survivals all happen
  function automatic logic [CELLS_W-1:0] random_cells();
    logic [CELLS_W-1:0] a, b;
    a = CELLS_W'($urandom);
    b = CELLS_W'($urandom);
    case ($urandom_range(0, 3))
      0: return a;
      1: return a & b;
      2: return a | b;
      default: return CELLS_W'(12'h007 << $urandom_range(0, 9));
    endcase
  endfunction

  // offer one item; called and returns at a falling edge
  task automatic offer_item(input logic item_op, input logic [ROW_IDX_W-1:0] idx,
                            input logic [CELLS_W-1:0] cells);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op        = item_op;
    row_index = idx;
    row_cells = cells;
    in_valid  = 1'b1;
    // accepted at the first rising edge with stall low
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    // out-of-range writes are dropped by the block, so they do not count
    if (item_op == lgs_pkg::OP_STEP || idx < GRID_H)
      items_sent++;
  endtask

  task automatic load_row(input logic [ROW_IDX_W-1:0] idx, input logic [CELLS_W-1:0] cells);
    offer_item(lgs_pkg::OP_WRITE, idx, cells);
  endtask

  task automatic step_generation();
    offer_item(lgs_pkg::OP_STEP, ROW_IDX_W'($urandom_range(0, 15)), CELLS_W'($urandom));
  endtask

  // receiver: random stall before every row, long hold-off on request
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request > 0) begin
        out_stall = 1'b1;
        while (hold_request > 0) begin
          @(negedge clk);
          hold_request--;
        end
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int kind;
    int nrows;
    logic [ROW_IDX_W-1:0] idx;

    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = lgs_pkg::OP_WRITE;
    row_index = '0;
    row_cells = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty grid, full edge rows, dropped out-of-range writes
    step_generation();
    load_row(4'd0, 12'hFFF);
    load_row(4'd9, 12'hFFF);
    load_row(4'd10, 12'hFFF);
    load_row(4'd15, 12'hFFF);
    step_generation();
    step_generation();
    // glider near the top-left corner and a still block in the bottom-right one
    load_row(4'd0, 12'h000);
    load_row(4'd1, 12'h002);
    load_row(4'd2, 12'h004);
    load_row(4'd3, 12'h007);
    load_row(4'd8, 12'hC00);
    load_row(4'd9, 12'hC00);
    step_generation();
    step_generation();
    // lone cells on both side columns die off
    load_row(4'd5, 12'h801);
    step_generation();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);

      // halfway: receiver holds off while steps keep coming, the block backs up
      if (hold_request == 0 && items_sent >= RANDOM_ITEMS / 2 &&
          items_sent < RANDOM_ITEMS / 2 + 10) begin
        hold_request = 80;
        load_row(4'd4, random_cells());
        step_generation();
        step_generation();
        step_generation();
      end

      if (kind < 6) begin
        // a few rows of new content, then one to three generations
        nrows = $urandom_range(1, GRID_H);
        repeat (nrows)
          load_row(ROW_IDX_W'($urandom_range(0, GRID_H - 1)), random_cells());
        repeat ($urandom_range(1, 3)) step_generation();
      end else if (kind < 8) begin
        // noise: any op, any index including dropped ones
        repeat ($urandom_range(1, 4))
          offer_item(logic'($urandom_range(0, 1)), ROW_IDX_W'($urandom_range(0, 15)),
                     CELLS_W'($urandom));
      end else begin
        // whole grid reload, then a step
        for (int y = 0; y < GRID_H; y++) begin
          idx = ROW_IDX_W'(y);
          load_row(idx, random_cells());
        end
        step_generation();
      end
    end
    calm     = 1'b0;
    in_valid = 1'b0;

    // drain every expected row, then let the output register settle
    while (rows_pending != 0) @(negedge clk);
    repeat (GRID_H + 12) @(posedge clk);

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
